>>> rtl/amu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amu_pkg
// Shared types, constants and helpers for the affine matrix update unit.
// ----------------------------------------------------------------------------
package amu_pkg;

  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned SCALE_W  = 31;
  localparam int unsigned ADDR_W   = 4;

  localparam logic [ADDR_W-1:0] ELEM_CNT   = 4'd12;
  localparam logic [ADDR_W-1:0] TRANS_BASE = 4'd9;

  typedef enum logic [2:0] {
    REQ_LOAD       = 3'd0,
    REQ_READ       = 3'd1,
    REQ_TRANSLATE  = 3'd2,
    REQ_PRETRANS   = 3'd3,
    REQ_SCALE      = 3'd4,
    REQ_UNIFORM    = 3'd5,
    REQ_PRESCALE   = 3'd6,
    REQ_GET_SCALE  = 3'd7
  } amu_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TRANS,
    ST_MUL,
    ST_ACC,
    ST_ROOT,
    ST_FINISH
  } amu_state_t;

  function automatic logic [ADDR_W-1:0] elem_addr(input logic [1:0] row,
                                                  input logic [1:0] col);
    return {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
  endfunction

endpackage

>>> rtl/amu_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amu_isqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module amu_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [amu_pkg::PROD_W-1:0]  radicand,
  output logic                        done,
  output logic [amu_pkg::ROOT_W-1:0]  root
);
  import amu_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic [PROD_W-1:0] rad;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic              running;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  always_comb begin
    rem_sh = {rem, rad[PROD_W-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    diff   = rem_sh - trial;
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(ROOT_W - 1);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (running) begin
      rad  <= {rad[PROD_W-3:0], 2'b00};
      rem  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

>>> rtl/affine_matrix_update_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_matrix_update_unit_top
// 4x3 Q-format affine matrix with element access and in-place update
// operations, built around one shared multiplier and a bit-serial root.
// ----------------------------------------------------------------------------
// One request is in flight at a time; in_stall is high from the accepting
// edge until its result has been moved into the output register, and the next
// request can be taken while that result still waits. The longer requests are
// paced by the single 32x32 multiplier (a multiply step and then an accumulate
// or write-back step per product) and, for get scale, by the square root unit
// that yields one root bit per cycle, started once for each of the three basis
// rows after their squaring.
module affine_matrix_update_unit_top #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   req_type,
  input  logic [3:0]                   elem_index,
  input  logic signed [31:0]           elem_value,
  input  logic signed [31:0]           vec_x,
  input  logic signed [31:0]           vec_y,
  input  logic signed [31:0]           vec_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           read_value,
  output logic [amu_pkg::SCALE_W-1:0]  scale_x,
  output logic [amu_pkg::SCALE_W-1:0]  scale_y,
  output logic [amu_pkg::SCALE_W-1:0]  scale_z,
  output logic                         overflow
);
  import amu_pkg::*;

  localparam int unsigned EW = (DATA_WIDTH < ELEM_W) ? DATA_WIDTH : ELEM_W;
  localparam logic signed [PROD_W-1:0] ELEM_MAX = (64'sd1 <<< (EW - 1)) - 64'sd1;
  localparam logic signed [PROD_W-1:0] ELEM_MIN = -ELEM_MAX - 64'sd1;
  localparam logic [PROD_W-1:0]        ELEM_MAX_U = ELEM_MAX;

  amu_state_t state, state_next;

  logic signed [ELEM_W-1:0] mat [ELEM_CNT];

  amu_req_t                 req_q;
  logic [ADDR_W-1:0]        idx_q;
  logic signed [ELEM_W-1:0] value_q;
  logic signed [ELEM_W-1:0] vec_q [3];

  logic [1:0]               row, row_next;
  logic [1:0]               col, col_next;
  logic signed [PROD_W-1:0] acc, acc_next;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ELEM_W-1:0] mul_b;

  logic [ADDR_W-1:0]        rd_addr;
  logic signed [ELEM_W-1:0] rd_data;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [PROD_W-1:0] wr_raw;
  logic signed [ELEM_W-1:0] wr_data;
  logic                     wr_hi, wr_lo, sat_hit;

  logic                     in_fire;
  logic                     rd_load;
  logic                     out_load;
  logic                     root_store;
  logic                     root_sat;
  logic [ROOT_W-1:0]        root_val;

  logic                     sq_start;
  logic                     sq_done;
  logic [ROOT_W-1:0]        sq_root;

  logic                     flag;
  logic signed [ELEM_W-1:0] rd_val;
  logic [SCALE_W-1:0]       scl [3];

  function automatic logic signed [ELEM_W-1:0] vsel(input logic [1:0] i);
    case (i)
      2'd0:    return vec_q[0];
      2'd1:    return vec_q[1];
      2'd2:    return vec_q[2];
      default: return '0;
    endcase
  endfunction

  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;

  // element read port
  assign rd_data = (rd_addr < ELEM_CNT) ? mat[rd_addr] : '0;

  assign prod_sh = prod >>> FRAC_BITS;

  // saturation to the element range
  always_comb begin
    wr_hi   = (wr_raw > ELEM_MAX);
    wr_lo   = (wr_raw < ELEM_MIN);
    wr_data = wr_hi ? ELEM_MAX[ELEM_W-1:0] :
              wr_lo ? ELEM_MIN[ELEM_W-1:0] : wr_raw[ELEM_W-1:0];
    sat_hit = wr_en && (wr_hi || wr_lo);
  end

  always_comb begin
    root_sat = ({{(PROD_W-ROOT_W){1'b0}}, sq_root} > ELEM_MAX_U);
    root_val = root_sat ? ELEM_MAX_U[ROOT_W-1:0] : sq_root;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    acc_next   = acc;
    rd_addr    = elem_addr(row, col);
    wr_en      = 1'b0;
    wr_addr    = elem_addr(row, col);
    wr_raw     = '0;
    mul_b      = rd_data;
    sq_start   = 1'b0;
    rd_load    = 1'b0;
    out_load   = 1'b0;
    root_store = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          row_next = 2'd0;
          col_next = 2'd0;
          case (amu_req_t'(req_type))
            REQ_LOAD, REQ_READ: state_next = ST_EXEC;
            REQ_TRANSLATE:      state_next = ST_TRANS;
            default:            state_next = ST_MUL;
          endcase
        end
      end
      ST_EXEC: begin
        rd_addr = idx_q;
        wr_addr = idx_q;
        wr_raw  = PROD_W'(value_q);
        wr_en   = (req_q == REQ_LOAD) && (idx_q < ELEM_CNT);
        rd_load = (req_q == REQ_READ) && (idx_q < ELEM_CNT);
        state_next = ST_FINISH;
      end
      ST_TRANS: begin
        rd_addr = TRANS_BASE + {2'b00, col};
        wr_addr = TRANS_BASE + {2'b00, col};
        wr_raw  = PROD_W'(rd_data) + PROD_W'(vsel(col));
        wr_en   = 1'b1;
        if (col == 2'd2) begin
          state_next = ST_FINISH;
        end else begin
          col_next = col + 2'd1;
        end
      end
      ST_MUL: begin
        case (req_q)
          REQ_SCALE:                 mul_b = vsel(col);
          REQ_UNIFORM:               mul_b = vec_q[0];
          REQ_PRESCALE, REQ_PRETRANS: mul_b = vsel(row);
          default:                   mul_b = rd_data;
        endcase
        state_next = ST_ACC;
      end
      ST_ACC: begin
        state_next = ST_MUL;
        case (req_q)
          REQ_PRETRANS: begin
            rd_addr  = TRANS_BASE + {2'b00, col};
            wr_addr  = TRANS_BASE + {2'b00, col};
            acc_next = ((row == 2'd0) ? PROD_W'(rd_data) : acc) + prod_sh;
            if (row == 2'd2) begin
              wr_en    = 1'b1;
              wr_raw   = acc_next;
              row_next = 2'd0;
              if (col == 2'd2) begin
                state_next = ST_FINISH;
              end else begin
                col_next = col + 2'd1;
              end
            end else begin
              row_next = row + 2'd1;
            end
          end
          REQ_GET_SCALE: begin
            acc_next = ((col == 2'd0) ? '0 : acc) + prod;
            if (col == 2'd2) begin
              sq_start   = 1'b1;
              state_next = ST_ROOT;
            end else begin
              col_next = col + 2'd1;
            end
          end
          default: begin
            wr_en  = 1'b1;
            wr_raw = prod_sh;
            if (col == 2'd2) begin
              col_next = 2'd0;
              if (row == ((req_q == REQ_PRESCALE) ? 2'd2 : 2'd3)) begin
                state_next = ST_FINISH;
              end else begin
                row_next = row + 2'd1;
              end
            end else begin
              col_next = col + 2'd1;
            end
          end
        endcase
      end
      ST_ROOT: begin
        if (sq_done) begin
          root_store = 1'b1;
          col_next   = 2'd0;
          if (row == 2'd2) begin
            state_next = ST_FINISH;
          end else begin
            row_next   = row + 2'd1;
            state_next = ST_MUL;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // request capture and working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_q    <= amu_req_t'(req_type);
      idx_q    <= elem_index;
      value_q  <= elem_value;
      vec_q[0] <= vec_x;
      vec_q[1] <= vec_y;
      vec_q[2] <= vec_z;
    end
    row  <= row_next;
    col  <= col_next;
    acc  <= acc_next;
    prod <= rd_data * mul_b;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_val <= '0;
      scl[0] <= '0;
      scl[1] <= '0;
      scl[2] <= '0;
    end else begin
      if (rd_load) begin
        rd_val <= rd_data;
      end
      if (root_store) begin
        scl[row] <= root_val[SCALE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (in_fire) begin
      flag <= 1'b0;
    end else if (sat_hit || (root_store && root_sat)) begin
      flag <= 1'b1;
    end
  end

  // matrix store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(ELEM_CNT); i++) begin
        mat[i] <= '0;
      end
    end else if (wr_en) begin
      mat[wr_addr] <= wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_value <= rd_val;
      scale_x    <= scl[0];
      scale_y    <= scl[1];
      scale_z    <= scl[2];
      overflow   <= flag;
    end
  end

  amu_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc_next),
    .done     (sq_done),
    .root     (sq_root)
  );

  // checks
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !wr_en)
    else $error("store written while idle");

  a_root_only_get_scale: assert property (@(posedge clk) disable iff (rst)
    sq_start |-> (req_q == REQ_GET_SCALE))
    else $error("root started for another request");

  a_scale_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({33'd0, scale_x} <= ELEM_MAX_U))
    else $error("scale above element maximum");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result shown without finishing");

endmodule
